[hdl/srr_pkg.sv]
package srr_pkg;

  localparam int unsigned BUFFER_SLOTS = 32;
  localparam int unsigned CNT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam logic [10:0] MAX_PAYLOAD = 11'd2047;
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(BUFFER_SLOTS - 1);

  typedef enum logic [1:0] {
    KIND_STALE   = 2'd0,
    KIND_DUP_ACK = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_EOF     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // One parked segment as it travels around the ring of cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] offset;
    logic [10:0] length;
    logic [7:0]  tag;
  } slot_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ack;
    logic [31:0] offset;
    logic [10:0] length;
    logic [7:0]  tag;
    logic        overflow;
    logic        last;
  } result_t;

endpackage

[hdl/srr_cell.sv]
module srr_cell
  import srr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  slot_t slot_in,
  output slot_t slot_out
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = shift ? slot_in : slot_r;
  end

  always_ff @(posedge clk) begin
    slot_r.offset <= slot_nxt.offset;
    slot_r.length <= slot_nxt.length;
    slot_r.tag    <= slot_nxt.tag;
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

  assign slot_out = slot_r;

endmodule

[hdl/srr_ctrl.sv]
module srr_ctrl
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seq_number,
  input  logic [10:0] in_data_length,
  input  logic [7:0]  in_payload_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_res,
  input  slot_t       head,
  output slot_t       tail,
  output logic        shift
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             prog_r, prog_nxt;
  logic             placed_r, placed_nxt;
  logic [31:0]      exp_r, exp_nxt;
  logic [31:0]      ack_r, ack_nxt;
  logic             fin_r, fin_nxt;
  slot_t            ins_r, ins_nxt;
  result_t          hold_r, hold_nxt;
  result_t          out_r, out_nxt;
  logic             outv_r, outv_nxt;
  logic             out_free;
  logic [10:0]      len_c;
  logic [31:0]      head_end;
  logic             step_prog;

  assign out_free = !outv_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign len_c = (in_data_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_data_length;
  assign head_end = head.offset + 32'(head.length);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prog_nxt   = prog_r;
    placed_nxt = placed_r;
    exp_nxt    = exp_r;
    ack_nxt    = ack_r;
    fin_nxt    = fin_r;
    ins_nxt    = ins_r;
    hold_nxt   = hold_r;
    out_nxt    = out_r;
    outv_nxt   = outv_r && out_stall;
    tail       = head;
    shift      = 1'b0;
    step_prog  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free && !fin_r) begin
          out_nxt = '0;
          out_nxt.last = 1'b1;
          cnt_nxt = '0;
          if (in_seq_number != exp_r) begin
            if (len_c == 11'd0) begin
              out_nxt.kind = KIND_EOF;
              out_nxt.ack  = in_seq_number;
              outv_nxt     = 1'b1;
              fin_nxt      = 1'b1;
            end else if (in_seq_number < exp_r) begin
              out_nxt.kind = KIND_STALE;
              out_nxt.ack  = in_seq_number + 32'(len_c);
              outv_nxt     = 1'b1;
            end else begin
              hold_nxt      = '0;
              hold_nxt.kind = KIND_DUP_ACK;
              hold_nxt.ack  = ack_r;
              ins_nxt       = '{1'b1, in_seq_number, len_c, in_payload_tag};
              placed_nxt    = 1'b0;
              state_nxt     = ST_INSERT;
            end
          end else begin
            exp_nxt         = in_seq_number + 32'(len_c);
            ack_nxt         = exp_nxt;
            hold_nxt        = '0;
            hold_nxt.kind   = KIND_DELIVER;
            hold_nxt.ack    = exp_nxt;
            hold_nxt.offset = in_seq_number;
            hold_nxt.length = len_c;
            hold_nxt.tag    = in_payload_tag;
            prog_nxt        = 1'b0;
            state_nxt       = ST_DRAIN;
          end
        end
      end

      ST_INSERT: begin
        shift = 1'b1;
        if (!head.valid && !placed_r) begin
          tail       = ins_r;
          placed_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          hold_nxt.overflow = !placed_nxt;
          state_nxt         = ST_FLUSH;
        end
      end

      ST_DRAIN: begin
        if (head.valid && head.offset == exp_r) begin
          // A match pushes the held result out, so it waits for a free output.
          if (out_free) begin
            shift           = 1'b1;
            step_prog       = 1'b1;
            out_nxt         = hold_r;
            out_nxt.last    = 1'b0;
            outv_nxt        = 1'b1;
            exp_nxt         = head_end;
            ack_nxt         = head_end;
            hold_nxt        = '0;
            hold_nxt.kind   = KIND_DELIVER;
            hold_nxt.ack    = head_end;
            hold_nxt.offset = head.offset;
            hold_nxt.length = head.length;
            hold_nxt.tag    = head.tag;
            tail.valid      = 1'b0;
          end
        end else begin
          shift = 1'b1;
          if (head.valid && head.offset < exp_r) begin
            tail.valid = 1'b0;
          end
        end
        if (shift) begin
          cnt_nxt  = cnt_r + 1'b1;
          prog_nxt = prog_r || step_prog;
          if (cnt_r == LAST_SLOT) begin
            cnt_nxt  = '0;
            prog_nxt = 1'b0;
            if (!(prog_r || step_prog)) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          outv_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ins_r    <= ins_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
    placed_r <= placed_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      prog_r  <= 1'b0;
      exp_r   <= '0;
      ack_r   <= '0;
      fin_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prog_r  <= prog_nxt;
      exp_r   <= exp_nxt;
      ack_r   <= ack_nxt;
      fin_r   <= fin_nxt;
      outv_r  <= outv_nxt;
    end
  end

  assign out_valid = outv_r;
  assign out_res   = out_r;

  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> (state_r == ST_INSERT || state_r == ST_DRAIN))
    else $error("ring rotated while no scan was running");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (outv_r && out_r.last))
    else $error("flush did not present the closing result");

  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("end of file flag cleared");

  a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken during a scan");

endmodule

[hdl/segment_reorder_receiver_top.sv]
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | seq_number, data_length, payload_tag
// out_    | output    | out_valid/out_stall| kind, ack, deliver fields, overflow, last
//
// A stale, end-of-file or finished transaction needs no turn of the ring.
// An early segment takes one full turn of the ring.
// An in-order segment takes one or more turns of the ring, where each
// turn of the ring is one pass over the slot cells and passes repeat while
// segments drain; output stalls on a delivery freeze the ring.
// Reset is synchronous and clears the slot valid bits and the control state apart from the placed flag.
module segment_reorder_receiver_top
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seq_number,
  input  logic [10:0] in_data_length,
  input  logic [7:0]  in_payload_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_ack_number,
  output logic [31:0] out_deliver_offset,
  output logic [10:0] out_deliver_length,
  output logic [7:0]  out_deliver_tag,
  output logic        out_buffer_overflow,
  output logic        out_last_of_run
);

  // The slot table is a ring of cells that rotates toward cell zero. The
  // controller inspects cell zero and feeds the possibly updated entry back
  // into the last cell, so one full turn visits every slot in slot order and
  // leaves the ring aligned again.
  slot_t   ring [BUFFER_SLOTS];
  slot_t   tail;
  logic    shift;
  result_t res;

  for (genvar i = 0; i < BUFFER_SLOTS; i++) begin : g_cell
    slot_t nb;
    if (i == BUFFER_SLOTS - 1) begin : g_wrap
      assign nb = tail;
    end else begin : g_next
      assign nb = ring[i+1];
    end
    srr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .slot_in  (nb),
      .slot_out (ring[i])
    );
  end

  // The controller holds the expected offset, the last ack and one pending
  // result, so it can mark the final result of a drain once a pass ends with no delivery.
  srr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_seq_number  (in_seq_number),
    .in_data_length (in_data_length),
    .in_payload_tag (in_payload_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .head           (ring[0]),
    .tail           (tail),
    .shift          (shift)
  );

  assign out_result_kind     = res.kind;
  assign out_ack_number      = res.ack;
  assign out_deliver_offset  = res.offset;
  assign out_deliver_length  = res.length;
  assign out_deliver_tag     = res.tag;
  assign out_buffer_overflow = res.overflow;
  assign out_last_of_run     = res.last;

endmodule
